FILE: hw/rtl/lcdns_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcdns_pkg: shared types and constants for the character-LCD nibble sequencer
// Request codes, the job record passed from front to back, and the power-up
// strobe table.
// ----------------------------------------------------------------------------
package lcdns_pkg;

  localparam logic [2:0] CMD_INIT  = 3'd0;
  localparam logic [2:0] CMD_INSTR = 3'd1;
  localparam logic [2:0] CMD_DATA  = 3'd2;
  localparam logic [2:0] CMD_GOTO  = 3'd3;
  localparam logic [2:0] CMD_NUM   = 3'd4;

  localparam logic [1:0] CFG_FIRST_ROW_BASE  = 2'd0;
  localparam logic [1:0] CFG_SECOND_ROW_BASE = 2'd1;
  localparam logic [1:0] CFG_HIDDEN_CELL     = 2'd2;

  localparam logic [6:0] FIRST_ROW_BASE_RST  = 7'd0;
  localparam logic [6:0] SECOND_ROW_BASE_RST = 7'd64;
  localparam logic [6:0] HIDDEN_CELL_RST     = 7'd79;

  localparam int         Q_DEPTH   = 2;
  localparam int         Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int         NUM_BITS  = 16;
  localparam int         NUM_DIGITS = 5;

  localparam logic [5:0] BYTE_WAIT  = 6'd2;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [3:0] INIT_LAST  = 4'd13;

  // Power-up strobes: raw 3,3,3,2 then 0x28, 0x0F, 0x06, 0x80, 0x01 by nibble.
  localparam logic [3:0] INIT_NIB [0:13] = '{
    4'h3, 4'h3, 4'h3, 4'h2,
    4'h2, 4'h8, 4'h0, 4'hF, 4'h0, 4'h6, 4'h8, 4'h0, 4'h0, 4'h1
  };
  localparam logic [5:0] INIT_WAIT [0:13] = '{
    6'd50, 6'd10, 6'd10, 6'd10,
    6'd22, 6'd0, 6'd12, 6'd0, 6'd12, 6'd0, 6'd12, 6'd0, 6'd2, 6'd0
  };

  typedef enum logic [1:0] {
    JOB_INIT,
    JOB_BYTE,
    JOB_NUM
  } job_kind_t;

  typedef struct packed {
    logic [6:0] first_row_base;
    logic [6:0] second_row_base;
    logic [6:0] hidden_cell;
  } cfg_t;

  typedef struct packed {
    job_kind_t  kind;
    logic       rs;
    logic [7:0] byte_v;   // byte to send, or the goto address for a number
    logic [19:0] digits;  // BCD, ten-thousands in the top nibble
  } job_t;

endpackage
`default_nettype wire

FILE: hw/rtl/lcdns_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcdns_front: request intake and classification
// Decodes each known request code into a job, forms goto addresses, and converts numbers
// to BCD with a shift-and-add-3 unit, one bit per cycle.
// ----------------------------------------------------------------------------
module lcdns_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire  [2:0]          in_cmd,
  input  wire  [7:0]          in_byte_value,
  input  wire  [1:0]          in_row,
  input  wire  [6:0]          in_column,
  input  wire  [15:0]         in_number,
  input  lcdns_pkg::cfg_t     cfg,
  output lcdns_pkg::job_t     job,
  output logic                job_valid,
  input  wire                 job_full
);
  import lcdns_pkg::*;

  logic        busy_r, busy_nxt;
  logic        job_vld_r, job_vld_nxt;
  job_t        job_r, job_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [15:0] bin_r, bin_nxt;
  logic [19:0] bcd_r, bcd_nxt;
  logic [19:0] bcd_adj;
  logic [6:0]  base;
  logic [7:0]  addr_sum;
  logic [7:0]  goto_addr;
  logic        push;
  logic        accept;

  assign push      = job_vld_r && !job_full;
  assign in_ready  = !busy_r && (!job_vld_r || push);
  assign accept    = in_valid && in_ready;
  assign job       = job_r;
  assign job_valid = job_vld_r;

  always_comb begin
    unique case (in_row)
      2'd0:    base = cfg.first_row_base;
      2'd1:    base = cfg.second_row_base;
      default: base = 7'd0;
    endcase
    addr_sum  = {1'b0, base} + {1'b0, in_column};
    goto_addr = {1'b1, addr_sum[6:0]};
  end

  // One double-dabble step: correct each digit, then shift the next bit in.
  always_comb begin
    for (int d = 0; d < NUM_DIGITS; d++) begin
      bcd_adj[d*4 +: 4] = (bcd_r[d*4 +: 4] >= 4'd5) ? bcd_r[d*4 +: 4] + 4'd3
                                                   : bcd_r[d*4 +: 4];
    end
  end

  always_comb begin
    busy_nxt    = busy_r;
    job_vld_nxt = job_vld_r;
    job_nxt     = job_r;
    cnt_nxt     = cnt_r;
    bin_nxt     = bin_r;
    bcd_nxt     = bcd_r;
    if (push) begin
      job_vld_nxt = 1'b0;
    end
    if (busy_r) begin
      bcd_nxt = {bcd_adj[18:0], bin_r[NUM_BITS-1]};
      bin_nxt = {bin_r[NUM_BITS-2:0], 1'b0};
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == 4'(NUM_BITS - 1)) begin
        busy_nxt       = 1'b0;
        job_vld_nxt    = 1'b1;
        job_nxt.digits = {bcd_adj[18:0], bin_r[NUM_BITS-1]};
        cnt_nxt        = 4'd0;
      end
    end else if (accept) begin
      job_nxt.digits = '0;
      unique case (in_cmd)
        CMD_INIT: begin
          job_nxt.kind   = JOB_INIT;
          job_nxt.rs     = 1'b0;
          job_nxt.byte_v = 8'h00;
          job_vld_nxt    = 1'b1;
        end
        CMD_INSTR, CMD_DATA: begin
          job_nxt.kind   = JOB_BYTE;
          job_nxt.rs     = (in_cmd == CMD_DATA);
          job_nxt.byte_v = in_byte_value;
          job_vld_nxt    = 1'b1;
        end
        CMD_GOTO: begin
          job_nxt.kind   = JOB_BYTE;
          job_nxt.rs     = 1'b0;
          job_nxt.byte_v = goto_addr;
          job_vld_nxt    = 1'b1;
        end
        CMD_NUM: begin
          job_nxt.kind   = JOB_NUM;
          job_nxt.rs     = 1'b0;
          job_nxt.byte_v = goto_addr;
          busy_nxt       = 1'b1;
          bin_nxt        = in_number;
          bcd_nxt        = '0;
          cnt_nxt        = 4'd0;
        end
        default: begin
          // Unknown request codes are taken and dropped.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      job_vld_r <= 1'b0;
      cnt_r     <= 4'd0;
    end else begin
      busy_r    <= busy_nxt;
      job_vld_r <= job_vld_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  a_busy_no_job: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !job_vld_r)
    else $error("front holds a finished job while converting");

  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> cnt_r == 4'd0)
    else $error("conversion counter not cleared outside a conversion");

endmodule
`default_nettype wire

FILE: hw/rtl/lcdns_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcdns_queue: job queue between front and back
// A short FIFO of job records so that intake and strobe output stall apart.
// ----------------------------------------------------------------------------
module lcdns_queue (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  input  lcdns_pkg::job_t  push_data,
  output logic             full,
  input  wire              pop,
  output lcdns_pkg::job_t  pop_data,
  output logic             not_empty
);
  import lcdns_pkg::*;

  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  job_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign full      = (count_r == CNT_W'(Q_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    priority if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("job pushed into a full queue");

endmodule
`default_nettype wire

FILE: hw/rtl/lcdns_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcdns_back: strobe sequencer
// Walks the job into the output register, one strobe per cycle unless stalled.
// ----------------------------------------------------------------------------
module lcdns_back (
  input  wire              clk,
  input  wire              rst_n,
  input  lcdns_pkg::cfg_t  cfg,
  input  lcdns_pkg::job_t  q_data,
  input  wire              q_not_empty,
  output logic             q_pop,
  output logic             out_valid,
  input  wire              out_ready,
  output logic [3:0]       out_nibble,
  output logic             out_reg_select,
  output logic [5:0]       out_wait_ms,
  output logic             out_last
);
  import lcdns_pkg::*;

  logic       active_r, active_nxt;
  job_t       cur_r, cur_nxt;
  logic [2:0] lead_r, lead_nxt;
  logic [3:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [3:0] nib_r, nib_nxt;
  logic       rs_r, rs_nxt;
  logic [5:0] wait_r, wait_nxt;
  logic       last_r, last_nxt;

  logic [2:0] pos;
  logic [7:0] byte_sel;
  logic       st_rs, st_last;
  logic [3:0] st_nib;
  logic [5:0] st_wait;
  logic [2:0] q_lead;
  logic       adv;

  assign pos = step_r[3:1];

  // Leading zero digits of the queued number; a lone zero keeps its last digit.
  always_comb begin
    priority if (q_data.digits[19:16] != 4'd0) q_lead = 3'd0;
    else if (q_data.digits[15:12] != 4'd0)     q_lead = 3'd1;
    else if (q_data.digits[11:8] != 4'd0)      q_lead = 3'd2;
    else if (q_data.digits[7:4] != 4'd0)       q_lead = 3'd3;
    else                                       q_lead = 3'd4;
  end

  // Strobe for the current step. A number job is a row of eight bytes:
  // address, five digits, space, park; the leading zero digits are skipped.
  always_comb begin
    byte_sel = cur_r.byte_v;
    st_rs    = cur_r.rs;
    st_last  = step_r[0];
    unique case (cur_r.kind)
      JOB_INIT: begin
        st_rs   = 1'b0;
        st_last = (step_r == INIT_LAST);
      end
      JOB_BYTE: begin
      end
      JOB_NUM: begin
        st_rs   = 1'b1;
        st_last = (step_r == 4'hF);
        unique case (pos)
          3'd0: begin
            byte_sel = cur_r.byte_v;
            st_rs    = 1'b0;
          end
          3'd1:    byte_sel = CHAR_ZERO | {4'h0, cur_r.digits[19:16]};
          3'd2:    byte_sel = CHAR_ZERO | {4'h0, cur_r.digits[15:12]};
          3'd3:    byte_sel = CHAR_ZERO | {4'h0, cur_r.digits[11:8]};
          3'd4:    byte_sel = CHAR_ZERO | {4'h0, cur_r.digits[7:4]};
          3'd5:    byte_sel = CHAR_ZERO | {4'h0, cur_r.digits[3:0]};
          3'd6:    byte_sel = CHAR_SPACE;
          default: begin
            byte_sel = {1'b1, cfg.hidden_cell};
            st_rs    = 1'b0;
          end
        endcase
      end
      default: begin
      end
    endcase
    if (cur_r.kind == JOB_INIT) begin
      st_nib  = INIT_NIB[step_r];
      st_wait = INIT_WAIT[step_r];
    end else begin
      st_nib  = step_r[0] ? byte_sel[3:0] : byte_sel[7:4];
      st_wait = step_r[0] ? 6'd0 : BYTE_WAIT;
    end
  end

  assign adv   = active_r && (!out_valid_r || out_ready);
  assign q_pop = q_not_empty && (!active_r || (adv && st_last));

  always_comb begin
    active_nxt    = active_r;
    cur_nxt       = cur_r;
    lead_nxt      = lead_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    nib_nxt       = nib_r;
    rs_nxt        = rs_r;
    wait_nxt      = wait_r;
    last_nxt      = last_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (adv) begin
      out_valid_nxt = 1'b1;
      nib_nxt       = st_nib;
      rs_nxt        = st_rs;
      wait_nxt      = st_wait;
      last_nxt      = st_last;
      if (st_last) begin
        active_nxt = 1'b0;
      end else if (cur_r.kind == JOB_NUM && step_r == 4'd1) begin
        step_nxt = {lead_r + 3'd1, 1'b0};
      end else begin
        step_nxt = step_r + 4'd1;
      end
    end
    if (q_pop) begin
      active_nxt = 1'b1;
      cur_nxt    = q_data;
      lead_nxt   = q_lead;
      step_nxt   = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      step_r      <= 4'd0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    lead_r <= lead_nxt;
    nib_r  <= nib_nxt;
    rs_r   <= rs_nxt;
    wait_r <= wait_nxt;
    last_r <= last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_nibble     = nib_r;
  assign out_reg_select = rs_r;
  assign out_wait_ms    = wait_r;
  assign out_last       = last_r;

  a_init_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r && cur_r.kind == JOB_INIT |-> step_r <= INIT_LAST)
    else $error("power-up sequence ran past its last strobe");

  a_byte_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r && cur_r.kind == JOB_BYTE |-> step_r <= 4'd1)
    else $error("byte job ran past its second strobe");

endmodule
`default_nettype wire

FILE: hw/rtl/char_lcd_nibble_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// A request passes the front job register, the job queue and the back end's
// job register to the output register; a print-number request first runs the
// bit-serial BCD conversion, which holds the intake. Jobs are queued and sent as
// one strobe per cycle while the receiver takes them; known requests have 2 to 16 strobes.
// Reset: synchronous active-low rst_n clears all control state and loads the
// register defaults (row bases 0 and 64, hidden cell 79).
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer: 4-bit character-LCD strobe generator
// Front intake and number conversion, a short job queue, and a strobe
// sequencer; holds the address configuration registers.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [2:0]  in_cmd,
  input  wire  [7:0]  in_byte_value,
  input  wire  [1:0]  in_row,
  input  wire  [6:0]  in_column,
  input  wire  [15:0] in_number,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [3:0]  out_nibble,
  output logic        out_reg_select,
  output logic [5:0]  out_wait_ms,
  output logic        out_last,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [6:0]  cfg_data
);
  import lcdns_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  job_t front_job, q_data;
  logic front_job_valid, q_full, q_pop, q_not_empty;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FIRST_ROW_BASE:  cfg_nxt.first_row_base  = cfg_data;
        CFG_SECOND_ROW_BASE: cfg_nxt.second_row_base = cfg_data;
        CFG_HIDDEN_CELL:     cfg_nxt.hidden_cell     = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_row_base  <= FIRST_ROW_BASE_RST;
      cfg_r.second_row_base <= SECOND_ROW_BASE_RST;
      cfg_r.hidden_cell     <= HIDDEN_CELL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lcdns_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_byte_value (in_byte_value),
    .in_row        (in_row),
    .in_column     (in_column),
    .in_number     (in_number),
    .cfg           (cfg_r),
    .job           (front_job),
    .job_valid     (front_job_valid),
    .job_full      (q_full)
  );

  lcdns_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (front_job_valid && !q_full),
    .push_data (front_job),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .not_empty (q_not_empty)
  );

  lcdns_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_data         (q_data),
    .q_not_empty    (q_not_empty),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_nibble     (out_nibble),
    .out_reg_select (out_reg_select),
    .out_wait_ms    (out_wait_ms),
    .out_last       (out_last)
  );

endmodule
`default_nettype wire

FILE: test/tb_char_lcd_nibble_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_char_lcd_nibble_sequencer: self-checking bench for the LCD nibble sequencer
// Drives display requests and register writes over valid/ready channels and
// predicts every enable strobe in the bench. Each strobe is checked against
// the oldest prediction. Both sides idle at random, and the receiver holds off
// long enough at one point to stall the request channel.
// ----------------------------------------------------------------------------
module tb_char_lcd_nibble_sequencer;
  import lcdns_pkg::*;

  localparam int         CYCLE_LIMIT   = 1_000_000;
  localparam int         SETTLE_CYCLES = 48;
  localparam int         RANDOM_PHASES = 4;
  localparam int         PHASE_ITEMS   = 50;
  localparam logic [2:0] CMD_FIRST_UNKNOWN = 3'd5;
  localparam logic [2:0] CMD_MID_UNKNOWN   = 3'd6;
  localparam logic [2:0] CMD_LAST_UNKNOWN  = 3'd7;
  localparam logic       RS_INSTR = 1'b0;
  localparam logic       RS_DATA  = 1'b1;
  localparam logic [5:0] STROBE_WAIT_MS = 6'd2;
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_SPACE = 8'h20;
  localparam logic [7:0] SET_DDRAM   = 8'h80;

  typedef struct packed {
    logic [3:0] nibble;
    logic       reg_select;
    logic [5:0] wait_ms;
    logic       last;
  } strobe_t;

  logic        clk;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic [2:0]  in_cmd         = '0;
  logic [7:0]  in_byte_value  = '0;
  logic [1:0]  in_row         = '0;
  logic [6:0]  in_column      = '0;
  logic [15:0] in_number      = '0;
  logic        out_ready      = 1'b0;
  logic        cfg_valid      = 1'b0;
  logic [1:0]  cfg_index      = '0;
  logic [6:0]  cfg_data       = '0;
  logic        in_ready;
  logic        out_valid;
  logic [3:0]  out_nibble;
  logic        out_reg_select;
  logic [5:0]  out_wait_ms;
  logic        out_last;
  logic        cfg_ready;

  // Bench copy of the address registers.
  logic [6:0]  row0_base   = FIRST_ROW_BASE_RST;
  logic [6:0]  row1_base   = SECOND_ROW_BASE_RST;
  logic [6:0]  parked_addr = HIDDEN_CELL_RST;

  strobe_t     expected_strobes[$];
  int          fail_count      = 0;
  int          requests_sent   = 0;
  int          ignored_sent    = 0;
  int          strobes_checked = 0;
  int          register_writes = 0;
  int          cycle_count     = 0;
  int          hold_len        = 0;
  bit          tx_idle_en      = 1'b1;
  bit          rx_idle_en      = 1'b1;

  char_lcd_nibble_sequencer dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_byte_value  (in_byte_value),
    .in_row         (in_row),
    .in_column      (in_column),
    .in_number      (in_number),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_nibble     (out_nibble),
    .out_reg_select (out_reg_select),
    .out_wait_ms    (out_wait_ms),
    .out_last       (out_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(12, 40);
    return $urandom_range(1, 3);
  endfunction

  // ---------------------------------------------------------------------------
  // Strobe prediction
  // ---------------------------------------------------------------------------
  task automatic push_strobe(input logic [3:0] nib, input logic rs, input logic [5:0] w);
    strobe_t s;
    s.nibble     = nib;
    s.reg_select = rs;
    s.wait_ms    = w;
    s.last       = 1'b0;
    expected_strobes.push_back(s);
  endtask

  // High nibble carries the wait; the low nibble follows at once.
  task automatic push_byte(input logic [7:0] b, input logic rs, input logic [5:0] w);
    push_strobe(b[7:4], rs, w);
    push_strobe(b[3:0], rs, 6'd0);
  endtask

  task automatic push_cursor_move(input logic [1:0] row, input logic [6:0] col);
    logic [7:0] base;
    logic [7:0] addr;
    if (row == 2'd0) base = {1'b0, row0_base};
    else if (row == 2'd1) base = {1'b0, row1_base};
    else base = 8'd0;
    addr = base + {1'b0, col};
    push_byte(addr | SET_DDRAM, RS_INSTR, STROBE_WAIT_MS);
  endtask

  task automatic predict_request(input logic [2:0] cmd, input logic [7:0] bv,
                                 input logic [1:0] row, input logic [6:0] col,
                                 input logic [15:0] num);
    int          start_size;
    int          tail;
    int unsigned value;
    int unsigned div;
    int unsigned digit;
    bit          started;
    strobe_t     s;
    start_size = expected_strobes.size();
    case (cmd)
      CMD_INIT: begin
        push_strobe(4'h3, RS_INSTR, 6'd50);
        push_strobe(4'h3, RS_INSTR, 6'd10);
        push_strobe(4'h3, RS_INSTR, 6'd10);
        push_strobe(4'h2, RS_INSTR, 6'd10);
        push_byte(8'h28, RS_INSTR, 6'd22);
        push_byte(8'h0F, RS_INSTR, 6'd12);
        push_byte(8'h06, RS_INSTR, 6'd12);
        push_byte(8'h80, RS_INSTR, 6'd12);
        push_byte(8'h01, RS_INSTR, STROBE_WAIT_MS);
      end
      CMD_INSTR: push_byte(bv, RS_INSTR, STROBE_WAIT_MS);
      CMD_DATA:  push_byte(bv, RS_DATA, STROBE_WAIT_MS);
      CMD_GOTO:  push_cursor_move(row, col);
      CMD_NUM: begin
        push_cursor_move(row, col);
        value   = num;
        started = 1'b0;
        // Leading zeros are dropped, but the units digit always prints.
        for (div = 10000; div != 0; div = div / 10) begin
          digit = value / div;
          value = value % div;
          if (digit != 0 || started || div == 1) begin
            started = 1'b1;
            push_byte(ASCII_ZERO + 8'(digit), RS_DATA, STROBE_WAIT_MS);
          end
        end
        push_byte(ASCII_SPACE, RS_DATA, STROBE_WAIT_MS);
        push_byte({1'b0, parked_addr} | SET_DDRAM, RS_INSTR, STROBE_WAIT_MS);
      end
      default: ;
    endcase
    if (expected_strobes.size() > start_size) begin
      tail = expected_strobes.size() - 1;
      s = expected_strobes[tail];
      s.last = 1'b1;
      expected_strobes[tail] = s;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Strobe checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    strobe_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_strobes.size() == 0) begin
        $error("unexpected strobe: nibble %0h rs %0d wait %0d last %0d",
               out_nibble, out_reg_select, out_wait_ms, out_last);
        fail_count++;
      end else begin
        want = expected_strobes.pop_front();
        strobes_checked++;
        if (out_nibble !== want.nibble) begin
          $error("nibble: expected %0h, got %0h", want.nibble, out_nibble);
          fail_count++;
        end
        if (out_reg_select !== want.reg_select) begin
          $error("reg_select: expected %0d, got %0d", want.reg_select, out_reg_select);
          fail_count++;
        end
        if (out_wait_ms !== want.wait_ms) begin
          $error("wait_ms: expected %0d, got %0d", want.wait_ms, out_wait_ms);
          fail_count++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_last);
          fail_count++;
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when a test asks for one.
  initial begin
    int n;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_len != 0) begin
        n = hold_len;
        hold_len = 0;
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic [2:0] cmd, input logic [7:0] bv,
                              input logic [1:0] row, input logic [6:0] col,
                              input logic [15:0] num);
    int gap;
    gap = (tx_idle_en && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_byte_value <= bv;
    in_row        <= row;
    in_column     <= col;
    in_number     <= num;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_request(cmd, bv, row, col, num);
    requests_sent++;
    if (cmd >= CMD_FIRST_UNKNOWN) ignored_sent++;
  endtask

  // Unused fields carry random values so that the block is seen to ignore them.
  task automatic send_random_request();
    logic [2:0]  cmd;
    logic [15:0] num;
    int          r;
    int          digits;
    r = $urandom_range(0, 99);
    if (r < 8) cmd = CMD_INIT;
    else if (r < 30) cmd = CMD_INSTR;
    else if (r < 52) cmd = CMD_DATA;
    else if (r < 72) cmd = CMD_GOTO;
    else if (r < 94) cmd = CMD_NUM;
    else cmd = 3'($urandom_range(CMD_FIRST_UNKNOWN, CMD_LAST_UNKNOWN));
    // Spread the numbers over every digit count.
    digits = $urandom_range(0, 5);
    case (digits)
      0: num = 16'($urandom);
      1: num = 16'($urandom_range(0, 9));
      2: num = 16'($urandom_range(10, 99));
      3: num = 16'($urandom_range(100, 999));
      4: num = 16'($urandom_range(1000, 9999));
      default: num = 16'($urandom_range(10000, 65535));
    endcase
    send_request(cmd, 8'($urandom), 2'($urandom), 7'($urandom), num);
  endtask

  // Lets every outstanding strobe arrive and the back end go idle.
  task automatic wait_until_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_strobes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [6:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_FIRST_ROW_BASE:  row0_base   = data;
      CFG_SECOND_ROW_BASE: row1_base   = data;
      CFG_HIDDEN_CELL:     parked_addr = data;
      default: ;
    endcase
    register_writes++;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [6:0] base0, input logic [6:0] base1,
                                input logic [6:0] parked);
    wait_until_quiet();
    write_register(CFG_FIRST_ROW_BASE, base0);
    write_register(CFG_SECOND_ROW_BASE, base1);
    write_register(CFG_HIDDEN_CELL, parked);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_power_up();
    send_request(CMD_INIT, 8'hFF, 2'd3, 7'h7F, 16'hFFFF);
  endtask

  task automatic test_bytes();
    send_request(CMD_INSTR, 8'h00, 2'd0, 7'd0, 16'd0);
    send_request(CMD_INSTR, 8'hFF, 2'd3, 7'h7F, 16'hFFFF);
    send_request(CMD_DATA, 8'hFF, 2'd0, 7'd0, 16'd0);
    send_request(CMD_DATA, 8'h00, 2'd3, 7'h7F, 16'hFFFF);
    send_request(CMD_DATA, 8'h5A, 2'd1, 7'h2A, 16'hA5A5);
  endtask

  task automatic test_goto_rows();
    send_request(CMD_GOTO, 8'hFF, 2'd0, 7'd0, 16'hFFFF);
    send_request(CMD_GOTO, 8'h00, 2'd1, 7'd127, 16'd0);
    send_request(CMD_GOTO, 8'h00, 2'd2, 7'd5, 16'd0);
    send_request(CMD_GOTO, 8'h00, 2'd3, 7'd127, 16'd0);
    send_request(CMD_GOTO, 8'h00, 2'd0, 7'd127, 16'd0);
    send_request(CMD_GOTO, 8'h00, 2'd1, 7'd0, 16'd0);
  endtask

  task automatic test_print_number();
    send_request(CMD_NUM, 8'hFF, 2'd0, 7'd0, 16'd0);
    send_request(CMD_NUM, 8'h00, 2'd1, 7'd3, 16'd7);
    send_request(CMD_NUM, 8'h00, 2'd2, 7'd127, 16'd10);
    send_request(CMD_NUM, 8'h00, 2'd3, 7'd64, 16'd99);
    send_request(CMD_NUM, 8'h00, 2'd0, 7'd10, 16'd100);
    send_request(CMD_NUM, 8'h00, 2'd1, 7'd127, 16'd10000);
    send_request(CMD_NUM, 8'h00, 2'd1, 7'd15, 16'd65535);
  endtask

  // Unknown request codes must vanish without disturbing their neighbors.
  task automatic test_ignored_codes();
    send_request(CMD_FIRST_UNKNOWN, 8'hFF, 2'd3, 7'h7F, 16'hFFFF);
    send_request(CMD_DATA, 8'h41, 2'd0, 7'd0, 16'd0);
    send_request(CMD_MID_UNKNOWN, 8'h00, 2'd0, 7'd0, 16'd0);
    send_request(CMD_LAST_UNKNOWN, 8'hAA, 2'd2, 7'h55, 16'h5555);
  endtask

  task automatic test_register_phases();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: apply_settings(7'd127, 7'd127, 7'd127);
        1: apply_settings(7'd0, 7'd0, 7'd0);
        2: apply_settings(7'($urandom), 7'($urandom), 7'($urandom));
        default: apply_settings($urandom_range(0, 1) ? 7'd127 : 7'd0, 7'($urandom), 7'd127);
      endcase
      // Vary idling per phase, one phase running flat out.
      tx_idle_en = (phase != 1) && (phase != 3);
      rx_idle_en = (phase != 1) && (phase != 2);
      for (int i = 0; i < PHASE_ITEMS; i++) send_random_request();
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // The receiver goes quiet while requests keep coming, so the request
  // channel has to stall until the strobes drain.
  task automatic test_backpressure();
    wait_until_quiet();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    hold_len   = 300;
    send_request(CMD_INIT, 8'($urandom), 2'($urandom), 7'($urandom), 16'($urandom));
    for (int i = 0; i < 9; i++)
      send_request(CMD_NUM, 8'($urandom), 2'($urandom), 7'($urandom),
                   16'($urandom_range(10000, 65535)));
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_power_up();
    test_bytes();
    test_goto_rows();
    test_print_number();
    test_ignored_codes();
    test_register_phases();
    test_backpressure();
    wait_until_quiet();
    $display("Sent %0d requests (%0d with unknown codes) and checked %0d strobes.",
             requests_sent, ignored_sent, strobes_checked);
    $display("Used %0d register writes, including all-zero and all-ones settings.",
             register_writes);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/lcdns_pkg.sv
hw/rtl/lcdns_front.sv
hw/rtl/lcdns_queue.sv
hw/rtl/lcdns_back.sv
hw/rtl/char_lcd_nibble_sequencer.sv
test/tb_char_lcd_nibble_sequencer.sv
